FILE: src/mcdl_pkg.sv
package mcdl_pkg;

  localparam int LINE_LENGTH_DEF = 4096;
  localparam int CHANNELS_DEF    = 2;

  localparam int SAMPLE_W = 16;
  localparam int BASE_W   = 12;
  localparam int DEPTH_W  = 11;
  localparam int GAIN_W   = 15;
  localparam int MIX_W    = 16;
  localparam int DELAY_W  = 13;

  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;

  localparam logic [BASE_W-1:0]  FIRST_DELAY_RST  = 12'd480;
  localparam logic [BASE_W-1:0]  SECOND_DELAY_RST = 12'd720;
  localparam logic [DEPTH_W-1:0] MOD_DEPTH_RST    = 11'd96;
  localparam logic [GAIN_W-1:0]  FEEDBACK_RST     = 15'd0;
  localparam logic [MIX_W-1:0]   WET_MIX_RST      = 16'd16384;
  localparam logic [MIX_W-1:0]   MIX_FULL         = 16'd32768;

  typedef enum logic [2:0] {
    REG_FIRST_DELAY  = 3'd0,
    REG_SECOND_DELAY = 3'd1,
    REG_MOD_DEPTH    = 3'd2,
    REG_SECOND_TAP   = 3'd3,
    REG_FEEDBACK     = 3'd4,
    REG_INVERT_FB    = 3'd5,
    REG_WET_MIX      = 3'd6
  } reg_idx_t;

endpackage

FILE: src/mcdl_in_if.sv
interface mcdl_in_if;
  import mcdl_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] audio_in;
  logic                       channel;
  logic signed [SAMPLE_W-1:0] mod_value;

  modport source (output valid, output audio_in, output channel, output mod_value,
                  input ready);
  modport sink (input valid, input audio_in, input channel, input mod_value,
                output ready);
endinterface

FILE: src/mcdl_out_if.sv
interface mcdl_out_if;
  import mcdl_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] audio_out;

  modport source (output valid, output audio_out, input ready);
  modport sink (input valid, input audio_out, output ready);
endinterface

FILE: src/mcdl_ram.sv
module mcdl_ram #(
  parameter int WIDTH = mcdl_pkg::SAMPLE_W,
  parameter int DEPTH = mcdl_pkg::CHANNELS_DEF * mcdl_pkg::LINE_LENGTH_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

FILE: src/modulated_chorus_delay_line.sv
// Each item passes through stages a to h and then the output register before its result is offered.
// Throughput: one item per cycle while nothing stalls. An item is held at stage e when one of its
// taps addresses a line entry that one of the three items ahead of it has yet to write.
// Reset (synchronous) restores the register defaults and zeroes the write position, then
// a clearing pass writes zero to all CHANNELS*LINE_LENGTH entries with sample.ready low;
// configuration writes are taken throughout.
module modulated_chorus_delay_line #(
  parameter int LINE_LENGTH = mcdl_pkg::LINE_LENGTH_DEF,
  parameter int CHANNELS    = mcdl_pkg::CHANNELS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  mcdl_in_if.sink                       sample,
  mcdl_out_if.source                    result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mcdl_pkg::PADDR_W-1:0]  paddr,
  input  logic [mcdl_pkg::PDATA_W-1:0]  pwdata,
  output logic [mcdl_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);
  import mcdl_pkg::*;

  localparam int DEPTH = CHANNELS * LINE_LENGTH;
  localparam int AW    = $clog2(DEPTH);
  localparam int WPW   = $clog2(LINE_LENGTH);
  localparam int SHIFT = DELAY_W + WPW;
  localparam longint unsigned RECIP =
    ((64'd1 << SHIFT) + 64'(LINE_LENGTH) - 64'd1) / 64'(LINE_LENGTH);
  localparam int RW = $clog2(RECIP + 64'd1);
  localparam int PW = DELAY_W + RW;

  localparam logic [RW-1:0]  RECIP_V  = RW'(RECIP);
  localparam logic [AW-1:0]  ROW_STEP = (CHANNELS > 1) ? AW'(LINE_LENGTH) : '0;
  localparam logic [WPW-1:0] WP_LAST  = WPW'(LINE_LENGTH - 1);
  localparam logic [WPW:0]   LEN_X    = (WPW+1)'(LINE_LENGTH);
  localparam logic [AW-1:0]  CLR_LAST = AW'(DEPTH - 1);

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] x;
    logic                       ch;
    logic [WPW-1:0]             wp;
    logic [AW-1:0]              waddr;
  } item_t;

  function automatic logic [AW-1:0] tap_addr(input logic [DELAY_W-1:0] d,
                                             input logic [DELAY_W-1:0] q,
                                             input logic [WPW-1:0]     wp,
                                             input logic               ch);
    logic [31:0]    rf;
    logic [WPW:0]   diff;
    logic [WPW-1:0] idx;
    rf   = 32'(d) - 32'(q) * 32'(LINE_LENGTH);
    diff = {1'b0, wp} - {1'b0, rf[WPW-1:0]};
    idx  = diff[WPW] ? WPW'(diff + LEN_X) : diff[WPW-1:0];
    tap_addr = (ch ? ROW_STEP : '0) + AW'(idx);
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] q15_sat(input logic signed [33:0] acc);
    logic signed [18:0] v;
    v = acc[33:15];
    if (v > 19'sd32767) begin
      q15_sat = 16'sh7fff;
    end else if (v < -19'sd32768) begin
      q15_sat = 16'sh8000;
    end else begin
      q15_sat = v[15:0];
    end
  endfunction

  // Configuration registers
  logic [BASE_W-1:0]  first_delay;
  logic [BASE_W-1:0]  second_delay;
  logic [DEPTH_W-1:0] mod_depth;
  logic               second_tap_enable;
  logic [GAIN_W-1:0]  feedback_gain;
  logic               invert_feedback;
  logic [MIX_W-1:0]   wet_mix;
  reg_idx_t           reg_sel;

  assign reg_sel = reg_idx_t'(paddr[PADDR_W-1:2]);
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_delay       <= FIRST_DELAY_RST;
      second_delay      <= SECOND_DELAY_RST;
      mod_depth         <= MOD_DEPTH_RST;
      second_tap_enable <= 1'b1;
      feedback_gain     <= FEEDBACK_RST;
      invert_feedback   <= 1'b0;
      wet_mix           <= WET_MIX_RST;
    end else if (psel && penable && pwrite) begin
      unique case (reg_sel)
        REG_FIRST_DELAY:  first_delay       <= pwdata[BASE_W-1:0];
        REG_SECOND_DELAY: second_delay      <= pwdata[BASE_W-1:0];
        REG_MOD_DEPTH:    mod_depth         <= pwdata[DEPTH_W-1:0];
        REG_SECOND_TAP:   second_tap_enable <= pwdata[0];
        REG_FEEDBACK:     feedback_gain     <= pwdata[GAIN_W-1:0];
        REG_INVERT_FB:    invert_feedback   <= pwdata[0];
        REG_WET_MIX:      wet_mix           <= pwdata[MIX_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_FIRST_DELAY:  prdata = PDATA_W'(first_delay);
      REG_SECOND_DELAY: prdata = PDATA_W'(second_delay);
      REG_MOD_DEPTH:    prdata = PDATA_W'(mod_depth);
      REG_SECOND_TAP:   prdata = PDATA_W'(second_tap_enable);
      REG_FEEDBACK:     prdata = PDATA_W'(feedback_gain);
      REG_INVERT_FB:    prdata = PDATA_W'(invert_feedback);
      REG_WET_MIX:      prdata = PDATA_W'(wet_mix);
      default:          prdata = '0;
    endcase
  end

  logic [MIX_W-1:0] mix;
  logic [MIX_W-1:0] dry;

  assign mix = (wet_mix > MIX_FULL) ? MIX_FULL : wet_mix;
  assign dry = MIX_FULL - mix;

  // Clearing pass and write position
  logic          clearing;
  logic [AW-1:0] clr_addr;
  logic [WPW-1:0] wp;
  logic [WPW-1:0] wp_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == CLR_LAST) begin
        clearing <= 1'b0;
      end
    end
  end

  // Pipeline stage valids and handshake
  logic v_a, v_b, v_c, v_d, v_e, v_f, v_g, v_h;
  logic mv_a, mv_b, mv_c, mv_d, mv_e, mv_f, mv_g, mv_h;
  logic hazard;
  logic accept;
  logic o_valid;
  logic signed [SAMPLE_W-1:0] o_data;

  item_t it_a, it_b, it_c, it_d, it_e, it_f, it_g, it_h;

  assign mv_h = v_h && (!o_valid || result.ready);
  assign mv_g = v_g && (!v_h || mv_h);
  assign mv_f = v_f && (!v_g || mv_g);
  assign mv_e = v_e && (!v_f || mv_f) && !hazard;
  assign mv_d = v_d && (!v_e || mv_e);
  assign mv_c = v_c && (!v_d || mv_d);
  assign mv_b = v_b && (!v_c || mv_c);
  assign mv_a = v_a && (!v_b || mv_b);

  assign sample.ready = !clearing && (!v_a || mv_a);
  assign accept       = sample.valid && sample.ready;

  assign wp_next = (wp == WP_LAST) ? '0 : wp + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
    end else if (accept && !sample.channel) begin
      wp <= wp_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_a     <= 1'b0;
      v_b     <= 1'b0;
      v_c     <= 1'b0;
      v_d     <= 1'b0;
      v_e     <= 1'b0;
      v_f     <= 1'b0;
      v_g     <= 1'b0;
      v_h     <= 1'b0;
      o_valid <= 1'b0;
    end else begin
      v_a     <= accept || (v_a && !mv_a);
      v_b     <= mv_a || (v_b && !mv_b);
      v_c     <= mv_b || (v_c && !mv_c);
      v_d     <= mv_c || (v_d && !mv_d);
      v_e     <= mv_d || (v_e && !mv_e);
      v_f     <= mv_e || (v_f && !mv_f);
      v_g     <= mv_f || (v_g && !mv_g);
      v_h     <= mv_g || (v_h && !mv_h);
      o_valid <= mv_h || (o_valid && !result.ready);
    end
  end

  // Stage a: register the item, form modulation times depth
  logic signed [SAMPLE_W-1:0] a_mod;
  logic [WPW-1:0]             in_wp;
  logic signed [27:0]         a_prod;

  assign in_wp  = sample.channel ? wp : wp_next;
  assign a_prod = 28'(a_mod) * 28'($signed({1'b0, mod_depth}));

  always_ff @(posedge clk) begin
    if (accept) begin
      it_a.x     <= sample.audio_in;
      it_a.ch    <= sample.channel;
      it_a.wp    <= in_wp;
      it_a.waddr <= (sample.channel ? ROW_STEP : '0) + AW'(in_wp);
      a_mod      <= sample.mod_value;
    end
  end

  // Stage b: tap delays, clamped to at least one
  logic signed [27:0]        b_prod;
  logic signed [DELAY_W-1:0] b_off;
  logic signed [DELAY_W:0]   dsum1;
  logic signed [DELAY_W:0]   dsum2;

  assign b_off = b_prod[27:15];
  assign dsum1 = $signed({2'b00, first_delay}) + (DELAY_W+1)'(b_off);
  assign dsum2 = $signed({2'b00, second_delay}) + (DELAY_W+1)'(b_off);

  always_ff @(posedge clk) begin
    if (mv_a) begin
      it_b   <= it_a;
      b_prod <= a_prod;
    end
  end

  // Stage c: quotient of each delay by the line length
  logic [DELAY_W-1:0] c_d1, c_d2;
  logic [PW-1:0]      qp1, qp2;

  assign qp1 = PW'(c_d1) * PW'(RECIP_V);
  assign qp2 = PW'(c_d2) * PW'(RECIP_V);

  always_ff @(posedge clk) begin
    if (mv_b) begin
      it_c <= it_b;
      c_d1 <= (dsum1 < 14'sd1) ? DELAY_W'(1) : dsum1[DELAY_W-1:0];
      c_d2 <= (dsum2 < 14'sd1) ? DELAY_W'(1) : dsum2[DELAY_W-1:0];
    end
  end

  // Stage d: tap addresses
  logic [DELAY_W-1:0] d_d1, d_d2, d_q1, d_q2;

  always_ff @(posedge clk) begin
    if (mv_c) begin
      it_d <= it_c;
      d_d1 <= c_d1;
      d_d2 <= c_d2;
      d_q1 <= DELAY_W'(qp1 >> SHIFT);
      d_q2 <= DELAY_W'(qp2 >> SHIFT);
    end
  end

  // Stage e: memory read, held back while an older item still has to write a tapped entry
  logic [AW-1:0] e_ra1, e_ra2;

  always_ff @(posedge clk) begin
    if (mv_d) begin
      it_e  <= it_d;
      e_ra1 <= tap_addr(d_d1, d_q1, it_d.wp, it_d.ch);
      e_ra2 <= tap_addr(d_d2, d_q2, it_d.wp, it_d.ch);
    end
  end

  assign hazard = v_e && (
      (v_f && (it_f.waddr == e_ra1 || it_f.waddr == e_ra2)) ||
      (v_g && (it_g.waddr == e_ra1 || it_g.waddr == e_ra2)) ||
      (v_h && (it_h.waddr == e_ra1 || it_h.waddr == e_ra2)));

  logic                       wr_en;
  logic [AW-1:0]              wr_addr;
  logic [SAMPLE_W-1:0]        wr_data;
  logic [SAMPLE_W-1:0]        rd1, rd2;
  logic signed [SAMPLE_W-1:0] h_wr;

  assign wr_en   = clearing || mv_h;
  assign wr_addr = clearing ? clr_addr : it_h.waddr;
  assign wr_data = clearing ? '0 : h_wr;

  mcdl_ram #(.WIDTH(SAMPLE_W), .DEPTH(DEPTH)) u_ram_tap1 (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (mv_e),
    .raddr (e_ra1),
    .rdata (rd1)
  );

  mcdl_ram #(.WIDTH(SAMPLE_W), .DEPTH(DEPTH)) u_ram_tap2 (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (mv_e),
    .raddr (e_ra2),
    .rdata (rd2)
  );

  // Stage f: delayed value, one tap or the mean of two
  logic signed [SAMPLE_W:0]   tap_sum;
  logic signed [SAMPLE_W-1:0] f_now;

  assign tap_sum = (SAMPLE_W+1)'($signed(rd1)) + (SAMPLE_W+1)'($signed(rd2));
  assign f_now   = second_tap_enable ? tap_sum[SAMPLE_W:1] : $signed(rd1);

  always_ff @(posedge clk) begin
    if (mv_e) begin
      it_f <= it_e;
    end
  end

  // Stage g: feedback and mix products
  logic signed [SAMPLE_W-1:0] g_now;

  always_ff @(posedge clk) begin
    if (mv_f) begin
      it_g  <= it_f;
      g_now <= f_now;
    end
  end

  logic signed [31:0] h_fb;
  logic signed [32:0] h_wet;
  logic signed [32:0] h_dry;

  always_ff @(posedge clk) begin
    if (mv_g) begin
      it_h  <= it_g;
      h_fb  <= 32'(g_now) * 32'($signed({1'b0, feedback_gain}));
      h_wet <= 33'(g_now) * 33'($signed({1'b0, mix}));
      h_dry <= 33'(it_g.x) * 33'($signed({1'b0, dry}));
    end
  end

  // Stage h: line write-back and output mix
  logic signed [33:0] acc_w;
  logic signed [33:0] acc_o;

  assign acc_w = invert_feedback ? (34'(it_h.x) <<< 15) - 34'(h_fb)
                                 : (34'(it_h.x) <<< 15) + 34'(h_fb);
  assign acc_o = 34'(h_wet) + 34'(h_dry);
  assign h_wr  = q15_sat(acc_w);

  always_ff @(posedge clk) begin
    if (mv_h) begin
      o_data <= q15_sat(acc_o);
    end
  end

  assign result.valid     = o_valid;
  assign result.audio_out = o_data;
endmodule

FILE: src/mcdl_checker.sv
module mcdl_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [mcdl_pkg::SAMPLE_W-1:0] out_data,
  input logic                          psel,
  input logic                          penable,
  input logic                          pwrite,
  input logic [mcdl_pkg::PADDR_W-1:0]  paddr,
  input logic [mcdl_pkg::PDATA_W-1:0]  pwdata,
  input logic [mcdl_pkg::PDATA_W-1:0]  prdata,
  input logic                          pready
);
  import mcdl_pkg::*;

  a_no_result_after_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result offered right after reset");

  a_clear_blocks_input: assert property (@(posedge clk)
    rst |=> !in_ready)
    else $error("item taken before the delay line was cleared");

  a_item_held: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_ready) |=> in_valid)
    else $error("waiting input item was withdrawn");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed or dropped");

  a_delay_readback: assert property (@(posedge clk) disable iff (rst)
    (psel && penable && pwrite && pready && paddr[PADDR_W-1:2] == REG_FIRST_DELAY)
    |=> (!(psel && !pwrite && paddr[PADDR_W-1:2] == REG_FIRST_DELAY) ||
         prdata == PDATA_W'($past(pwdata[BASE_W-1:0]))))
    else $error("first delay register does not read back the written value");
endmodule

bind modulated_chorus_delay_line mcdl_checker u_mcdl_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (sample.valid),
  .in_ready  (sample.ready),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .out_data  (result.audio_out),
  .psel      (psel),
  .penable   (penable),
  .pwrite    (pwrite),
  .paddr     (paddr),
  .pwdata    (pwdata),
  .prdata    (prdata),
  .pready    (pready)
);
